### rtl/core/bscr_pkg.sv
// ----------------------------------------------------------------------------
// bscr_pkg: shared types and constants of the bus slave command responder
// Holds the command constants, the pending reply kinds and the structs that
// carry decode and slot status between the submodules.
// ----------------------------------------------------------------------------
package bscr_pkg;

    localparam logic [7:0]  BCAST_CODE  = 8'h20;
    localparam logic [7:0]  BCAST_REPLY = 8'hA0;
    localparam logic [7:0]  BCAST_ADDR  = 8'h00;
    localparam logic [7:0]  BCAST_LEN   = 8'd12;
    localparam logic [7:0]  WRITE_LEN   = 8'd5;
    localparam logic [7:0]  READ_LEN    = 8'd0;
    localparam logic [15:0] FIXED_TEMP  = 16'd2850;
    localparam logic [6:0]  SLOT_BASE   = 7'd5;
    localparam logic [6:0]  ELAPSED_MAX = 7'd127;
    localparam int          PAY_BYTES   = 12;

    // Item kinds on the input channel.
    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Result kinds on the output channel.
    localparam logic OUT_SETPOINT = 1'b0;
    localparam logic OUT_REPLY    = 1'b1;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_OWN_ADDR         = 3'd0;
    localparam logic [2:0] REG_WRITE_CODE       = 3'd1;
    localparam logic [2:0] REG_READ_CODE        = 3'd2;
    localparam logic [2:0] REG_READ_REPLY_CODE  = 3'd3;
    localparam logic [2:0] REG_WRITE_REPLY_CODE = 3'd4;

    typedef enum logic [1:0] {
        KIND_BCAST = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } reply_kind_t;

    // Outcome of decoding one frame.
    typedef struct packed {
        logic        hit;       // frame is addressed to us and is a known command
        logic        setpoint;  // frame also produces a setpoint update
        reply_kind_t kind;      // reply type to send when the slot expires
        logic [6:0]  delay;     // slot length in milliseconds
    } dec_t;

    // Status of the reply slot timer.
    typedef struct packed {
        logic        waiting;   // a reply is pending
        logic        fire;      // the current beat is the tick that ends the slot
        reply_kind_t kind;      // reply type of the pending reply
    } slot_t;

    // Slot length of a broadcast frame: 5 ms plus 20 ms per slice position.
    function automatic logic [6:0] bcast_delay(input logic [1:0] slice);
        logic [6:0] d;
        case (slice)
            2'd0:    d = 7'd5;
            2'd1:    d = 7'd25;
            2'd2:    d = 7'd45;
            2'd3:    d = 7'd65;
            default: d = 7'd5;
        endcase
        return d;
    endfunction

endpackage

### rtl/core/bscr_decode.sv
// ----------------------------------------------------------------------------
// bscr_decode: frame decoder
// Checks address, command and length of a frame, picks the setpoint bytes
// out of the payload and works out the reply type and slot length.
// ----------------------------------------------------------------------------
module bscr_decode
(
    input  logic [7:0]         frame_addr,
    input  logic [7:0]         frame_cmd,
    input  logic [7:0]         frame_len,
    input  logic [31:0]        payload_head,
    input  logic [63:0]        payload_tail,
    input  logic [2:0]         own_addr,
    input  logic [7:0]         write_code,
    input  logic [7:0]         read_code,
    output bscr_pkg::dec_t     dec,
    output logic [7:0]         set_enable,
    output logic signed [15:0] set_current
);
    import bscr_pkg::*;

    logic [7:0] pay [PAY_BYTES];
    logic [1:0] slice;
    logic       addr_ok;
    logic       is_bcast;
    logic       is_write;
    logic       is_read;
    logic       to_bcast;
    logic [7:0] bc_en;
    logic [7:0] bc_hi;
    logic [7:0] bc_lo;

    // The slice position is (own_addr - 1) mod 4.
    assign slice = own_addr[1:0] - 2'd1;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pay[i] = payload_head[31 - 8 * i -: 8];
        end
        for (int i = 0; i < 8; i++)
        begin
            pay[i + 4] = payload_tail[63 - 8 * i -: 8];
        end
    end

    assign to_bcast = (frame_addr == BCAST_ADDR);
    assign addr_ok  = to_bcast || (frame_addr == {5'd0, own_addr});
    assign is_bcast = (frame_cmd == BCAST_CODE) && (frame_len == BCAST_LEN);
    assign is_write = !is_bcast && (frame_cmd == write_code) && (frame_len == WRITE_LEN);
    assign is_read  = !is_bcast && !is_write && (frame_cmd == read_code)
                      && (frame_len == READ_LEN);

    always_comb
    begin
        case (slice)
            2'd0:
            begin
                bc_en = pay[0]; bc_hi = pay[1]; bc_lo = pay[2];
            end
            2'd1:
            begin
                bc_en = pay[3]; bc_hi = pay[4]; bc_lo = pay[5];
            end
            2'd2:
            begin
                bc_en = pay[6]; bc_hi = pay[7]; bc_lo = pay[8];
            end
            2'd3:
            begin
                bc_en = pay[9]; bc_hi = pay[10]; bc_lo = pay[11];
            end
            default:
            begin
                bc_en = pay[0]; bc_hi = pay[1]; bc_lo = pay[2];
            end
        endcase
    end

    always_comb
    begin
        dec.hit      = addr_ok && (is_bcast || is_write || is_read);
        dec.setpoint = addr_ok && (is_bcast || is_write);
        dec.delay    = to_bcast ? bcast_delay(slice) : SLOT_BASE;
        // The reply type follows the command code alone, read first.
        if (frame_cmd == read_code)
        begin
            dec.kind = KIND_READ;
        end
        else if (frame_cmd == BCAST_CODE)
        begin
            dec.kind = KIND_BCAST;
        end
        else
        begin
            dec.kind = KIND_WRITE;
        end
    end

    assign set_enable  = is_bcast ? bc_en : pay[0];
    assign set_current = is_bcast ? $signed({bc_hi, bc_lo}) : $signed({pay[3], pay[4]});

endmodule

### rtl/core/bscr_slot.sv
// ----------------------------------------------------------------------------
// bscr_slot: reply slot timer
// Holds the pending reply and counts millisecond ticks until its time slot
// has run out.
// ----------------------------------------------------------------------------
module bscr_slot
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           beat,
    input  logic           func,
    input  bscr_pkg::dec_t dec,
    output bscr_pkg::slot_t slot
);
    import bscr_pkg::*;

    logic        waiting_reg;
    logic        waiting_next;
    reply_kind_t kind_reg;
    reply_kind_t kind_next;
    logic [6:0]  delay_reg;
    logic [6:0]  delay_next;
    logic [6:0]  elapsed_reg;
    logic [6:0]  elapsed_next;
    logic [6:0]  elapsed_inc;
    logic        fire;

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 7'd1;
    assign fire        = beat && (func == FUNC_TICK) && waiting_reg
                         && (elapsed_inc >= delay_reg);

    always_comb
    begin
        waiting_next = waiting_reg;
        kind_next    = kind_reg;
        delay_next   = delay_reg;
        elapsed_next = elapsed_reg;
        if (beat)
        begin
            if (func == FUNC_TICK)
            begin
                if (waiting_reg)
                begin
                    if (fire)
                    begin
                        waiting_next = 1'b0;
                        elapsed_next = 7'd0;
                    end
                    else
                    begin
                        elapsed_next = elapsed_inc;
                    end
                end
            end
            else if (!waiting_reg && dec.hit)
            begin
                waiting_next = 1'b1;
                kind_next    = dec.kind;
                delay_next   = dec.delay;
                elapsed_next = 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg <= 1'b0;
            kind_reg    <= KIND_BCAST;
            delay_reg   <= 7'd0;
            elapsed_reg <= 7'd0;
        end
        else
        begin
            waiting_reg <= waiting_next;
            kind_reg    <= kind_next;
            delay_reg   <= delay_next;
            elapsed_reg <= elapsed_next;
        end
    end

    assign slot.waiting = waiting_reg;
    assign slot.fire    = fire;
    assign slot.kind    = kind_reg;

`ifndef SYNTHESIS
    // The tick counter only runs while a reply is pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        !waiting_reg |-> (elapsed_reg == 7'd0))
        else $error("slot counter nonzero while idle");

    // A reply that fires returns the timer to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> !waiting_reg)
        else $error("slot timer still waiting after reply");

    // A pending slot never shrinks or grows while it is being timed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (waiting_reg && !fire) |=> $stable(delay_reg) && waiting_reg)
        else $error("slot length changed while waiting");
`endif

endmodule

### rtl/core/bus_slave_command_responder_top.sv
// ----------------------------------------------------------------------------
// bus_slave_command_responder_top: slave end of a multidrop command bus
// Decodes parsed frames, emits setpoint updates and times status replies.
// ----------------------------------------------------------------------------
// Usage. Each input beat is either a parsed frame (func = 0) or a one
// millisecond tick (func = 1). A frame addressed to the own address or to
// broadcast address 0 that carries broadcast control, single write or read
// status is taken while the block is idle. Both control commands produce a
// setpoint beat on the output in the cycle after the frame is accepted. Every
// taken frame opens a time slot of 5 ms, or 5 + 20 * ((own address - 1) mod 4)
// ms for a frame to broadcast address 0; the tick that ends the slot produces
// a reply beat in the next cycle. Other frames, frames that arrive during a slot
// and idle ticks give no output beat.
// Throughput is one input beat per cycle while the receiver keeps up: the decode,
// the slot counter update and the output register load all happen in the same
// cycle, and a beat that gives output shows it valid in the cycle after it is taken.
// When the receiver stalls, the output register holds its beat and in_ready
// drops until that beat is taken; in_ready stays high while the output
// register is empty or being drained in the same cycle.
// Reset clears the pending slot, empties the output register and loads the
// configuration registers with their defaults. Configuration writes through
// cfg_we take effect at once and are meant for an idle block.
// ----------------------------------------------------------------------------
module bus_slave_command_responder_top
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration write port.
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    // Input channel.
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [7:0]         frame_addr,
    input  logic [7:0]         frame_cmd,
    input  logic [7:0]         frame_len,
    input  logic [31:0]        payload_head,
    input  logic [63:0]        payload_tail,
    input  logic [7:0]         meas_state,
    input  logic [15:0]        meas_current,
    // Output channel.
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_kind,
    output logic [7:0]         set_enable,
    output logic signed [15:0] set_current,
    output logic [2:0]         reply_addr,
    output logic [7:0]         reply_code,
    output logic [7:0]         reply_state,
    output logic [15:0]        reply_temp,
    output logic [15:0]        reply_current
);
    import bscr_pkg::*;

    // Configuration registers.
    logic [2:0] own_addr_reg;
    logic [7:0] write_code_reg;
    logic [7:0] read_code_reg;
    logic [7:0] read_reply_code_reg;
    logic [7:0] write_reply_code_reg;

    // Output register.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_kind_reg;
    logic [7:0]         set_enable_reg;
    logic signed [15:0] set_current_reg;
    logic [2:0]         reply_addr_reg;
    logic [7:0]         reply_code_reg;
    logic [7:0]         reply_state_reg;
    logic [15:0]        reply_temp_reg;
    logic [15:0]        reply_current_reg;

    dec_t               dec;
    slot_t              slot;
    logic [7:0]         dec_enable;
    logic signed [15:0] dec_current;
    logic               beat;
    logic               emit_setpoint;
    logic               emit_reply;
    logic [7:0]         reply_code_sel;

    assign in_ready = !out_valid_reg || out_ready;
    assign beat     = in_valid && in_ready;

    bscr_decode u_decode
    (
        .frame_addr   (frame_addr),
        .frame_cmd    (frame_cmd),
        .frame_len    (frame_len),
        .payload_head (payload_head),
        .payload_tail (payload_tail),
        .own_addr     (own_addr_reg),
        .write_code   (write_code_reg),
        .read_code    (read_code_reg),
        .dec          (dec),
        .set_enable   (dec_enable),
        .set_current  (dec_current)
    );

    bscr_slot u_slot
    (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (beat),
        .func  (func),
        .dec   (dec),
        .slot  (slot)
    );

    // A setpoint is only produced by a frame taken while idle.
    assign emit_setpoint = beat && (func == FUNC_FRAME) && !slot.waiting && dec.setpoint;
    assign emit_reply    = slot.fire;

    // The reply code is looked up when the reply goes out.
    always_comb
    begin
        case (slot.kind)
            KIND_READ:  reply_code_sel = read_reply_code_reg;
            KIND_BCAST: reply_code_sel = BCAST_REPLY;
            KIND_WRITE: reply_code_sel = write_reply_code_reg;
            default:    reply_code_sel = write_reply_code_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg         <= 3'd1;
            write_code_reg       <= 8'd16;
            read_code_reg        <= 8'd3;
            read_reply_code_reg  <= 8'd131;
            write_reply_code_reg <= 8'd144;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OWN_ADDR:         own_addr_reg         <= cfg_data[2:0];
                REG_WRITE_CODE:       write_code_reg       <= cfg_data;
                REG_READ_CODE:        read_code_reg        <= cfg_data;
                REG_READ_REPLY_CODE:  read_reply_code_reg  <= cfg_data;
                REG_WRITE_REPLY_CODE: write_reply_code_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_setpoint || emit_reply)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload of the output register; unused fields of each kind are zero.
    always_ff @(posedge clk)
    begin
        if (emit_setpoint)
        begin
            out_kind_reg      <= OUT_SETPOINT;
            set_enable_reg    <= dec_enable;
            set_current_reg   <= dec_current;
            reply_addr_reg    <= 3'd0;
            reply_code_reg    <= 8'd0;
            reply_state_reg   <= 8'd0;
            reply_temp_reg    <= 16'd0;
            reply_current_reg <= 16'd0;
        end
        else if (emit_reply)
        begin
            out_kind_reg      <= OUT_REPLY;
            set_enable_reg    <= 8'd0;
            set_current_reg   <= 16'sd0;
            reply_addr_reg    <= own_addr_reg;
            reply_code_reg    <= reply_code_sel;
            reply_state_reg   <= meas_state;
            reply_temp_reg    <= FIXED_TEMP;
            reply_current_reg <= meas_current;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_kind      = out_kind_reg;
    assign set_enable    = set_enable_reg;
    assign set_current   = set_current_reg;
    assign reply_addr    = reply_addr_reg;
    assign reply_code    = reply_code_reg;
    assign reply_state   = reply_state_reg;
    assign reply_temp    = reply_temp_reg;
    assign reply_current = reply_current_reg;

`ifndef SYNTHESIS
    // A matching control frame shows up as a setpoint beat in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_setpoint |=> out_valid && (out_kind == OUT_SETPOINT))
        else $error("setpoint beat missing");

    // The tick that closes the slot gives a reply with the fixed temperature.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_reply |=> out_valid && (out_kind == OUT_REPLY) && (reply_temp == FIXED_TEMP))
        else $error("reply beat missing or malformed");

    // A frame that arrives during a slot is dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (beat && (func == FUNC_FRAME) && slot.waiting) |=> !out_valid)
        else $error("frame during slot produced a beat");

    // A setpoint and a reply never compete for the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(emit_setpoint && emit_reply))
        else $error("setpoint and reply in the same cycle");
`endif

endmodule

### tb/responder_checker.sv
// ----------------------------------------------------------------------------
// responder_checker: predicts and checks the command responder's output beats
// Follows the configuration port and every accepted input beat and keeps
// its own copy of the reply slot. It queues the setpoint and reply beats
// that the block owes and compares each output beat field by field.
// ----------------------------------------------------------------------------
module responder_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               func,
    input  logic [7:0]         frame_addr,
    input  logic [7:0]         frame_cmd,
    input  logic [7:0]         frame_len,
    input  logic [31:0]        payload_head,
    input  logic [63:0]        payload_tail,
    input  logic [7:0]         meas_state,
    input  logic [15:0]        meas_current,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               out_kind,
    input  logic [7:0]         set_enable,
    input  logic signed [15:0] set_current,
    input  logic [2:0]         reply_addr,
    input  logic [7:0]         reply_code,
    input  logic [7:0]         reply_state,
    input  logic [15:0]        reply_temp,
    input  logic [15:0]        reply_current,
    output int unsigned        fail_count,
    output int unsigned        pending_count,
    output logic               slot_open
);
    timeunit 1ns;
    timeprecision 1ps;
    import bscr_pkg::*;

    localparam logic [6:0] SLOT_STEP_MS = 7'd20;

    typedef struct {
        logic               out_kind;
        logic [7:0]         set_enable;
        logic signed [15:0] set_current;
        logic [2:0]         reply_addr;
        logic [7:0]         reply_code;
        logic [7:0]         reply_state;
        logic [15:0]        reply_temp;
        logic [15:0]        reply_current;
    } result_beat_t;

    result_beat_t expected_beats[$];

    logic [2:0]  own_id;
    logic [7:0]  write_code_q;
    logic [7:0]  read_code_q;
    logic [7:0]  read_reply_q;
    logic [7:0]  write_reply_q;
    reply_kind_t slot_kind;
    logic [6:0]  slot_len;
    logic [6:0]  slot_ms;

    task automatic compare_field(input string name, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_beat();
        result_beat_t want;
        if (expected_beats.size() == 0) begin
            $error("out_kind: expected no beat, got %0d", out_kind);
            fail_count++;
        end else begin
            want = expected_beats.pop_front();
            compare_field("out_kind", want.out_kind, out_kind);
            compare_field("set_enable", want.set_enable, set_enable);
            compare_field("set_current", want.set_current, set_current);
            compare_field("reply_addr", want.reply_addr, reply_addr);
            compare_field("reply_code", want.reply_code, reply_code);
            compare_field("reply_state", want.reply_state, reply_state);
            compare_field("reply_temp", want.reply_temp, reply_temp);
            compare_field("reply_current", want.reply_current, reply_current);
        end
    endtask

    task automatic predict_response();
        logic [7:0]   pay [PAY_BYTES];
        logic [95:0]  whole;
        logic [2:0]   id_less_one;
        logic [1:0]   slice;
        int unsigned  base;
        int unsigned  cur_at;
        logic         hit_bcast;
        logic         hit_write;
        logic         hit_read;
        result_beat_t r;
        id_less_one = own_id - 3'd1;
        slice = id_less_one[1:0];
        whole = {payload_head, payload_tail};
        for (int i = 0; i < PAY_BYTES; i++)
            pay[i] = whole[95 - 8 * i -: 8];
        r = '{default: '0};
        if (func == FUNC_TICK) begin
            if (slot_open) begin
                if (slot_ms < ELAPSED_MAX)
                    slot_ms++;
                if (slot_ms >= slot_len) begin
                    r.out_kind = OUT_REPLY;
                    r.reply_addr = own_id;
                    case (slot_kind)
                        KIND_READ:  r.reply_code = read_reply_q;
                        KIND_BCAST: r.reply_code = BCAST_REPLY;
                        default:    r.reply_code = write_reply_q;
                    endcase
                    r.reply_state = meas_state;
                    r.reply_temp = FIXED_TEMP;
                    r.reply_current = meas_current;
                    expected_beats.push_back(r);
                    slot_open = 1'b0;
                    slot_ms = '0;
                end
            end
        end else if (!slot_open &&
                     (frame_addr == {5'd0, own_id} || frame_addr == BCAST_ADDR)) begin
            // Broadcast control wins over write, and write over read.
            hit_bcast = frame_cmd == BCAST_CODE && frame_len == BCAST_LEN;
            hit_write = !hit_bcast && frame_cmd == write_code_q && frame_len == WRITE_LEN;
            hit_read = !hit_bcast && !hit_write && frame_cmd == read_code_q &&
                       frame_len == READ_LEN;
            if (hit_bcast || hit_write) begin
                base = hit_bcast ? 3 * slice : 0;
                cur_at = hit_bcast ? base + 1 : 3;
                r.out_kind = OUT_SETPOINT;
                r.set_enable = pay[base];
                r.set_current = {pay[cur_at], pay[cur_at + 1]};
                expected_beats.push_back(r);
            end
            if (hit_bcast || hit_write || hit_read) begin
                slot_len = (frame_addr == BCAST_ADDR) ?
                           SLOT_BASE + {5'd0, slice} * SLOT_STEP_MS : SLOT_BASE;
                // The reply type follows the command byte alone.
                if (frame_cmd == read_code_q)
                    slot_kind = KIND_READ;
                else if (frame_cmd == BCAST_CODE)
                    slot_kind = KIND_BCAST;
                else
                    slot_kind = KIND_WRITE;
                slot_open = 1'b1;
                slot_ms = '0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            own_id = 3'd1;
            write_code_q = 8'd16;
            read_code_q = 8'd3;
            read_reply_q = 8'd131;
            write_reply_q = 8'd144;
            slot_open = 1'b0;
            slot_kind = KIND_BCAST;
            slot_len = '0;
            slot_ms = '0;
            expected_beats.delete();
            fail_count = 0;
        end else begin
            // The beat leaving now was owed by an earlier input beat.
            if (out_valid && out_ready)
                check_beat();
            if (cfg_we) begin
                case (cfg_index)
                    REG_OWN_ADDR:         own_id = cfg_data[2:0];
                    REG_WRITE_CODE:       write_code_q = cfg_data;
                    REG_READ_CODE:        read_code_q = cfg_data;
                    REG_READ_REPLY_CODE:  read_reply_q = cfg_data;
                    REG_WRITE_REPLY_CODE: write_reply_q = cfg_data;
                    default:              ;
                endcase
            end
            if (in_valid && in_ready)
                predict_response();
        end
        pending_count = expected_beats.size();
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the bus slave command responder
// Drives frames and millisecond ticks with random gaps, stalls the output
// side at random, steps the configuration through several settings and
// leaves prediction and checking to responder_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bscr_pkg::*;

    // Cycles with no beat on either channel before the run is declared hung.
    // The long output hold-off is the slowest legal stretch by far.
    localparam int unsigned STALL_LIMIT     = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned GAP_MAX         = 12;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned PHASE_ITEMS     = 55;
    // Index 7 lies past the register list and must be ignored.
    localparam logic [2:0]  REG_SPARE       = 3'd7;
    localparam logic [2:0]  RESET_OWN_ADDR   = 3'd1;
    localparam logic [7:0]  RESET_WRITE_CODE = 8'd16;
    localparam logic [7:0]  RESET_READ_CODE  = 8'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [7:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               func;
    logic [7:0]         frame_addr;
    logic [7:0]         frame_cmd;
    logic [7:0]         frame_len;
    logic [31:0]        payload_head;
    logic [63:0]        payload_tail;
    logic [7:0]         meas_state;
    logic [15:0]        meas_current;
    logic               out_valid;
    logic               out_ready;
    logic               out_kind;
    logic [7:0]         set_enable;
    logic signed [15:0] set_current;
    logic [2:0]         reply_addr;
    logic [7:0]         reply_code;
    logic [7:0]         reply_state;
    logic [15:0]        reply_temp;
    logic [15:0]        reply_current;

    int unsigned        fail_count;
    int unsigned        pending_count;
    logic               slot_open;

    // Stimulus keeps its own copy of the address and codes so that it can
    // build frames the block will take.
    logic [2:0]         own_id;
    logic [7:0]         wr_code;
    logic [7:0]         rd_code;

    int unsigned        idle_cycles = 0;
    int unsigned        hold_off_asks = 0;
    int unsigned        tx_beats = 0;
    logic               tx_steady = 1'b0;
    logic               rx_steady = 1'b0;

    bus_slave_command_responder_top dut (.*);

    responder_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog. Any accepted beat on either channel restarts the count, so
    // only a real hang reaches the limit.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Output side. Every beat is preceded by a drawn number of stall cycles,
    // with stretches where it takes beats back to back. A hold-off asked for
    // by the stimulus keeps ready low long enough for the block to fill up
    // and drop in_ready while beats keep being offered.
    initial
    begin
        int unsigned gap;
        int unsigned rx_beats;
        int unsigned hold_offs_done;
        rx_beats = 0;
        hold_offs_done = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (rx_beats % 24 == 0)
                rx_steady = ($urandom_range(0, 2) == 0);
            rx_beats++;
            if (hold_offs_done != hold_off_asks) begin
                hold_offs_done++;
                gap = HOLD_OFF_CYCLES;
            end else begin
                gap = rx_steady ? 0 : $urandom_range(0, GAP_MAX);
            end
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    // Offers one input beat after a drawn gap and returns at the falling
    // edge after it was accepted. valid stays high across back-to-back beats.
    task automatic send_beat(input logic f, input logic [7:0] a, input logic [7:0] c,
                             input logic [7:0] l, input logic [31:0] h,
                             input logic [63:0] t, input logic [7:0] st,
                             input logic [15:0] cur);
        int unsigned gap;
        if (tx_beats % 24 == 0)
            tx_steady = ($urandom_range(0, 2) == 0);
        tx_beats++;
        gap = tx_steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func <= f;
        frame_addr <= a;
        frame_cmd <= c;
        frame_len <= l;
        payload_head <= h;
        payload_tail <= t;
        meas_state <= st;
        meas_current <= cur;
        in_valid <= 1'b1;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    // Frame beats carry random measurements; the block only reads them on
    // the tick that ends a slot.
    task automatic send_frame(input logic [7:0] a, input logic [7:0] c,
                              input logic [7:0] l, input logic [31:0] h,
                              input logic [63:0] t);
        send_beat(FUNC_FRAME, a, c, l, h, t, 8'($urandom), 16'($urandom));
    endtask

    // Tick beats carry random frame fields, which the block must ignore.
    task automatic send_tick(input logic [7:0] st, input logic [15:0] cur);
        send_beat(FUNC_TICK, 8'($urandom), 8'($urandom), 8'($urandom), $urandom,
                  {$urandom, $urandom}, st, cur);
    endtask

    // Brings the block to idle: ticks close any open slot, then all owed
    // beats are collected and a few more cycles let the output register
    // empty before anything is reconfigured.
    task automatic settle();
        while (slot_open)
            send_tick(8'($urandom), 16'($urandom));
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [2:0] id, input logic [7:0] wc,
                                 input logic [7:0] rc, input logic [7:0] rrc,
                                 input logic [7:0] wrc);
        settle();
        write_reg(REG_OWN_ADDR, {5'd0, id});
        write_reg(REG_WRITE_CODE, wc);
        write_reg(REG_READ_CODE, rc);
        write_reg(REG_READ_REPLY_CODE, rrc);
        write_reg(REG_WRITE_REPLY_CODE, wrc);
        write_reg(REG_SPARE, 8'($urandom));
        cfg_we <= 1'b0;
        own_id = id;
        wr_code = wc;
        rd_code = rc;
    endtask

    // Random traffic. While a slot is open most beats are ticks, so slots
    // run out and replies come; while idle most beats are frames the block
    // will take, with random payloads, and the rest are frames with a wrong
    // address, command or length and stray ticks. Only beats that move the
    // block's state count toward n_items.
    task automatic run_random(input int unsigned n_items);
        int unsigned counted;
        int unsigned pick;
        reply_kind_t kind;
        logic [7:0]  a;
        logic [7:0]  c;
        logic [7:0]  l;
        counted = 0;
        while (counted < n_items) begin
            pick = $urandom_range(0, 99);
            kind = reply_kind_t'($urandom_range(0, 2));
            a = ($urandom_range(0, 9) < 3) ? BCAST_ADDR : {5'd0, own_id};
            case (kind)
                KIND_BCAST: begin c = BCAST_CODE; l = BCAST_LEN; end
                KIND_WRITE: begin c = wr_code;    l = WRITE_LEN; end
                default:    begin c = rd_code;    l = READ_LEN;  end
            endcase
            if (slot_open && pick < 85) begin
                send_tick(8'($urandom), 16'($urandom));
                counted++;
            end else if (!slot_open && pick < 10) begin
                send_tick(8'($urandom), 16'($urandom));
            end else begin
                if (!slot_open && pick >= 75) begin
                    case ($urandom_range(0, 3))
                        0: a = 8'($urandom);
                        1: c = 8'($urandom);
                        2: l = 8'($urandom);
                        default:
                        begin
                            a = 8'($urandom);
                            c = 8'($urandom);
                            l = 8'($urandom);
                        end
                    endcase
                end else if (!slot_open) begin
                    counted++;
                end
                send_frame(a, c, l, $urandom, {$urandom, $urandom});
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_FRAME;
        frame_addr = '0;
        frame_cmd = '0;
        frame_len = '0;
        payload_head = '0;
        payload_tail = '0;
        meas_state = '0;
        meas_current = '0;
        own_id = RESET_OWN_ADDR;
        wr_code = RESET_WRITE_CODE;
        rd_code = RESET_READ_CODE;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed part on the reset configuration.
        // A tick with no open slot is ignored.
        send_tick(8'h00, 16'h0000);
        // Frames the block must drop: foreign address, unknown command,
        // read with a payload, write with the broadcast length.
        send_frame(8'hFF, rd_code, READ_LEN, '0, '0);
        send_frame({5'd0, own_id}, 8'h77, READ_LEN, '0, '0);
        send_frame({5'd0, own_id}, rd_code, 8'hFF, '1, '1);
        send_frame({5'd0, own_id}, wr_code, BCAST_LEN, '1, '1);
        // Read to the own address opens a 5 ms slot; a valid write during
        // the slot is dropped. The fifth tick brings the reply.
        send_frame({5'd0, own_id}, rd_code, READ_LEN, '0, '0);
        send_frame({5'd0, own_id}, wr_code, WRITE_LEN, '1, '1);
        repeat (4) send_tick(8'h00, 16'h0000);
        send_tick(8'hFF, 16'hFFFF);
        // Write with full enable byte and the largest positive current.
        send_frame({5'd0, own_id}, wr_code, WRITE_LEN, 32'hFF00_FF7F,
                   64'hFF00_0000_0000_0000);
        repeat (5) send_tick(8'($urandom), 16'($urandom));
        // Broadcast control with the most negative current in the slice.
        send_frame(BCAST_ADDR, BCAST_CODE, BCAST_LEN, 32'h0080_0000, '0);
        repeat (5) send_tick(8'($urandom), 16'($urandom));
        run_random(PHASE_ITEMS);

        // Address 4 with the longest broadcast slot, all-ones and
        // all-zero codes, and a long output hold-off.
        apply_setting(3'd4, 8'hFF, 8'h00, 8'h00, 8'hFF);
        hold_off_asks <= hold_off_asks + 1;
        run_random(PHASE_ITEMS);

        // Write and read share the broadcast code, so the decode order and
        // the reply type both come into play.
        apply_setting(3'd2, BCAST_CODE, BCAST_CODE, 8'h5A, 8'hA5);
        run_random(PHASE_ITEMS);

        // Write and read share one code.
        apply_setting(3'd3, 8'h55, 8'h55, 8'($urandom), 8'($urandom));
        run_random(PHASE_ITEMS);

        apply_setting(3'd1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        hold_off_asks <= hold_off_asks + 1;
        run_random(PHASE_ITEMS);

        apply_setting(3'($urandom_range(1, 4)), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
        run_random(PHASE_ITEMS);

        settle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### bus_slave_command_responder_top.f
rtl/core/bscr_pkg.sv
rtl/core/bscr_decode.sv
rtl/core/bscr_slot.sv
rtl/core/bus_slave_command_responder_top.sv
tb/responder_checker.sv
tb/tb_top.sv
